FILE: hw/rtl/segmented_expert_matmul_bias_top_assert.svh
// Assertion macros for the grouped matmul block.
// Used by segmented_expert_matmul_bias_top; expects signals clk and rst in scope.
`ifndef SEGMENTED_EXPERT_MATMUL_BIAS_TOP_ASSERT_SVH
`define SEGMENTED_EXPERT_MATMUL_BIAS_TOP_ASSERT_SVH

// same-cycle implication
`define SEMMB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SEMMB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/semmb_pkg.sv
// Shared types and constants for the grouped matmul block.
// No dependencies.
`default_nettype none
package semmb_pkg;

  localparam int NUM_EXPERTS_DEF = 8;
  localparam int INNER_DIM_DEF   = 64;
  localparam int OUT_COLS_DEF    = 16;

  localparam int VALUE_W  = 16;
  localparam int RESULT_W = 32;
  localparam int ACC_W    = 48;
  localparam int CFG_W    = 7;

  localparam logic [6:0] INNER_LEN_RST   = 7'd64;
  localparam logic [4:0] OUT_COLS_RST    = 5'd16;
  localparam logic       BIAS_ENABLE_RST = 1'b1;

  typedef enum logic [1:0] {
    CMD_ACT    = 2'd0,
    CMD_WEIGHT = 2'd1,
    CMD_BIAS   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_INNER_LEN   = 2'd0,
    REG_OUT_COLS    = 2'd1,
    REG_BIAS_ENABLE = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic wt_we;
    logic bias_we;
    logic act_rd;
    logic bias_rd;
    logic s1_valid;
    logic s1_mac;
    logic s1_base;
    logic s2_valid;
    logic s2_first;
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/semmb_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none
module semmb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/semmb_cell.sv
// One output-column MAC cell: weight and bias RAMs, accumulator, unload stage.
// Depends on semmb_pkg and semmb_ram.
`default_nettype none
module semmb_cell #(
  parameter int NUM_EXPERTS = 8,
  parameter int INNER_DIM   = 64,
  parameter int IDX         = 0,
  parameter int WA_W        = 9,
  parameter int BA_W        = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  semmb_pkg::cell_ctrl_t       ctrl,
  input  logic [3:0]                  col,
  input  logic [WA_W-1:0]             wt_waddr,
  input  logic [WA_W-1:0]             wt_raddr,
  input  logic [BA_W-1:0]             bias_waddr,
  input  logic [BA_W-1:0]             bias_raddr,
  input  logic signed [15:0]          ld_value,
  input  logic signed [15:0]          act_value,
  input  logic [31:0]                 chain_in,
  output logic [31:0]                 chain_out
);
  import semmb_pkg::*;

  logic                    hit;
  logic [VALUE_W-1:0]      w_rd;
  logic [VALUE_W-1:0]      b_rd;
  logic signed [31:0]      prod;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] acc;
  logic [RESULT_W-1:0]     sat;

  assign hit = (32'(col) == IDX);

  semmb_ram #(.WIDTH(VALUE_W), .DEPTH(NUM_EXPERTS * INNER_DIM)) u_wt (
    .clk   (clk),
    .we    (ctrl.wt_we && hit),
    .waddr (wt_waddr),
    .wdata (ld_value),
    .re    (ctrl.act_rd),
    .raddr (wt_raddr),
    .rdata (w_rd)
  );

  semmb_ram #(.WIDTH(VALUE_W), .DEPTH(NUM_EXPERTS)) u_bias (
    .clk   (clk),
    .we    (ctrl.bias_we && hit),
    .waddr (bias_waddr),
    .wdata (ld_value),
    .re    (ctrl.bias_rd),
    .raddr (bias_raddr),
    .rdata (b_rd)
  );

  always_ff @(posedge clk) begin
    if (ctrl.s1_valid) begin
      if (ctrl.s1_mac) begin
        prod <= $signed(w_rd) * act_value;
      end else begin
        prod <= '0;
      end
      base <= ctrl.s1_base ? {{(ACC_W - 24){b_rd[15]}}, b_rd, 8'h00} : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.s2_valid) begin
      acc <= (ctrl.s2_first ? base : acc) + ACC_W'(prod);
    end
  end

  always_comb begin
    if (&acc[ACC_W-1:31] || ~|acc[ACC_W-1:31]) begin
      sat = acc[31:0];
    end else if (acc[ACC_W-1]) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      chain_out <= sat;
    end else if (ctrl.shift) begin
      chain_out <= chain_in;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/segmented_expert_matmul_bias_top.sv
// Grouped matmul with bias: a row of OUT_COLS MAC cells, one per output column.
// Pipeline: an element's weight is read and its product registered, then it is accumulated;
// a row end passes s1_end, s2_end and s3_end, then results load into the cell chain and leave
// one beat per cycle while m_tready is high. Throughput: one element or load per cycle while
// s_tready is high; a row-ending element holds off input until the chain has unloaded.
// Reset: synchronous; clears control, counters, accumulators and config; RAMs keep contents.
`default_nettype none
`include "segmented_expert_matmul_bias_top_assert.svh"
module segmented_expert_matmul_bias_top #(
  parameter int NUM_EXPERTS = semmb_pkg::NUM_EXPERTS_DEF,
  parameter int INNER_DIM   = semmb_pkg::INNER_DIM_DEF,
  parameter int OUT_COLS    = semmb_pkg::OUT_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // expert[2:0], inner_pos[8:3], column[12:9], value[28:13], zero fill above
  input  logic [31:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_value[31:0], result_column[35:32], zero fill above
  output logic [39:0] m_tdata,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import semmb_pkg::*;

  localparam int CNT_W = (INNER_DIM > 1) ? $clog2(INNER_DIM) : 1;
  localparam int LEN_W = $clog2(INNER_DIM + 1);
  localparam int NC_W  = $clog2(OUT_COLS + 1);
  localparam int COL_W = (OUT_COLS > 1) ? $clog2(OUT_COLS) : 1;
  localparam int WA_W  = (NUM_EXPERTS * INNER_DIM > 1) ? $clog2(NUM_EXPERTS * INNER_DIM) : 1;
  localparam int BA_W  = (NUM_EXPERTS > 1) ? $clog2(NUM_EXPERTS) : 1;

  logic [6:0] inner_len;
  logic [4:0] out_cols;
  logic       bias_enable;

  logic [CNT_W-1:0] count;
  logic [2:0]       row_expert;

  logic [2:0]         expert;
  logic [5:0]         inner_pos;
  logic [3:0]         column;
  logic signed [15:0] value;

  logic             beat_in;
  logic             is_act;
  logic             first;
  logic [2:0]       exp_sel;
  logic             exp_ok;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] cnt_p1;
  logic             row_end;
  logic [NC_W-1:0]  ncols_eff;

  logic               s1_valid, s1_mac, s1_base, s1_first, s1_end;
  logic [NC_W-1:0]    s1_ncols;
  logic signed [15:0] s1_val;
  logic               s2_valid, s2_first, s2_end;
  logic [NC_W-1:0]    s2_ncols;
  logic               s3_end;
  logic [NC_W-1:0]    s3_ncols;

  logic [NC_W-1:0]  remain;
  logic [COL_W-1:0] col_cnt;

  cell_ctrl_t      ctrl;
  logic [WA_W-1:0] wt_waddr, wt_raddr;
  logic [BA_W-1:0] bias_addr;
  logic [31:0]     chain [OUT_COLS + 1];

  assign expert    = s_tdata[2:0];
  assign inner_pos = s_tdata[8:3];
  assign column    = s_tdata[12:9];
  assign value     = s_tdata[28:13];

  assign beat_in = s_tvalid && s_tready;
  assign is_act  = beat_in && (s_tuser == CMD_ACT);
  assign first   = (count == '0);
  assign exp_sel = first ? expert : row_expert;
  assign exp_ok  = (32'(exp_sel) < NUM_EXPERTS);
  assign cnt_p1  = LEN_W'(count) + LEN_W'(1);
  assign row_end = (cnt_p1 >= len_eff);

  always_comb begin
    if (inner_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(inner_len) > INNER_DIM) begin
      len_eff = LEN_W'(INNER_DIM);
    end else begin
      len_eff = LEN_W'(inner_len);
    end
    if (out_cols == '0) begin
      ncols_eff = NC_W'(1);
    end else if (32'(out_cols) > OUT_COLS) begin
      ncols_eff = NC_W'(OUT_COLS);
    end else begin
      ncols_eff = NC_W'(out_cols);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_len   <= INNER_LEN_RST;
      out_cols    <= OUT_COLS_RST;
      bias_enable <= BIAS_ENABLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INNER_LEN:   inner_len   <= cfg_data;
        REG_OUT_COLS:    out_cols    <= cfg_data[4:0];
        REG_BIAS_ENABLE: bias_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      row_expert <= '0;
    end else if (is_act) begin
      count <= row_end ? '0 : CNT_W'(cnt_p1);
      if (first) begin
        row_expert <= expert;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_end   <= 1'b0;
      s2_valid <= 1'b0;
      s2_end   <= 1'b0;
      s3_end   <= 1'b0;
    end else begin
      s1_valid <= is_act;
      s1_end   <= is_act && row_end;
      s2_valid <= s1_valid;
      s2_end   <= s1_end;
      s3_end   <= s2_end;
    end
  end

  always_ff @(posedge clk) begin
    s1_mac   <= exp_ok;
    s1_base  <= bias_enable && exp_ok;
    s1_first <= first;
    s1_ncols <= ncols_eff;
    s1_val   <= value;
    s2_first <= s1_first;
    s2_ncols <= s1_ncols;
    s3_ncols <= s2_ncols;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remain  <= '0;
      col_cnt <= '0;
    end else if (s3_end) begin
      remain  <= s3_ncols;
      col_cnt <= '0;
    end else if (m_tvalid && m_tready) begin
      remain  <= remain - NC_W'(1);
      col_cnt <= col_cnt + COL_W'(1);
    end
  end

  assign m_tvalid = (remain != '0);
  assign m_tlast  = (remain == NC_W'(1));
  assign m_tdata  = {4'b0000, 4'(col_cnt), chain[0]};
  assign s_tready = !(m_tvalid || s1_end || s2_end || s3_end);

  assign wt_raddr  = WA_W'(32'(exp_sel) * INNER_DIM + 32'(count));
  assign wt_waddr  = WA_W'(32'(expert) * INNER_DIM + 32'(inner_pos));
  assign bias_addr = BA_W'(expert);

  always_comb begin
    ctrl.wt_we    = beat_in && (s_tuser == CMD_WEIGHT) && (32'(expert) < NUM_EXPERTS)
                    && (32'(inner_pos) < INNER_DIM) && (32'(column) < OUT_COLS);
    ctrl.bias_we  = beat_in && (s_tuser == CMD_BIAS) && (32'(expert) < NUM_EXPERTS)
                    && (32'(column) < OUT_COLS);
    ctrl.act_rd   = is_act;
    ctrl.bias_rd  = is_act && first;
    ctrl.s1_valid = s1_valid;
    ctrl.s1_mac   = s1_mac;
    ctrl.s1_base  = s1_base && s1_first;
    ctrl.s2_valid = s2_valid;
    ctrl.s2_first = s2_first;
    ctrl.load     = s3_end;
    ctrl.shift    = m_tvalid && m_tready;
  end

  assign chain[OUT_COLS] = '0;

  for (genvar j = 0; j < OUT_COLS; j++) begin : g_cell
    semmb_cell #(
      .NUM_EXPERTS (NUM_EXPERTS),
      .INNER_DIM   (INNER_DIM),
      .IDX         (j),
      .WA_W        (WA_W),
      .BA_W        (BA_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .col        (column),
      .wt_waddr   (wt_waddr),
      .wt_raddr   (wt_raddr),
      .bias_waddr (bias_addr),
      .bias_raddr (bias_addr),
      .ld_value   (value),
      .act_value  (s1_val),
      .chain_in   (chain[j+1]),
      .chain_out  (chain[j])
    );
  end

  `SEMMB_ASSERT_NOW(a_no_input_while_unloading, m_tvalid, !s_tready, "input taken during unload")
  `SEMMB_ASSERT_NOW(a_load_into_empty_chain, s3_end, remain == '0, "chain loaded while busy")
  `SEMMB_ASSERT_NEXT(a_last_ends_row, m_tvalid && m_tready && m_tlast, !m_tvalid,
                     "beats continue after row end")
  `SEMMB_ASSERT_NOW(a_column_in_range, m_tvalid, 32'(col_cnt) < OUT_COLS, "column out of range")

endmodule
`default_nettype wire

FILE: bench/semmb_result_checker.sv
// Result checker for segmented_expert_matmul_bias_top: watches the input, config and
// output channels, predicts every output beat and compares it against the block.
// Depends on semmb_pkg for widths, command and register codes.
module semmb_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  output int          failures,
  output int          outstanding,
  output int          checked
);
  import semmb_pkg::*;

  localparam int WT_DEPTH = NUM_EXPERTS_DEF * INNER_DIM_DEF * OUT_COLS_DEF;
  localparam longint SAT_HI = 64'sh7fffffff;
  localparam longint SAT_LO = -64'sh80000000;

  typedef struct packed {
    logic signed [RESULT_W-1:0] value;
    logic [3:0]                 column;
    logic                       last;
  } col_result_t;

  col_result_t               pending_cols[$];
  logic signed [VALUE_W-1:0] weight_mem [WT_DEPTH];
  logic signed [VALUE_W-1:0] bias_mem [NUM_EXPERTS_DEF * OUT_COLS_DEF];
  longint                    col_sum [OUT_COLS_DEF];
  int                        elem_count;
  int                        row_expert;
  logic [6:0]                inner_len;
  logic [4:0]                out_cols;
  logic                      bias_enable;

  function automatic int clamp_len(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic signed [31:0] saturate32(longint v);
    if (v > SAT_HI) return 32'sh7fffffff;
    if (v < SAT_LO) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic note_failure(string what, col_result_t want, col_result_t got);
    if (failures < 10) begin
      $display("[%0t] %s: expected value %0d col %0d last %0b, got value %0d col %0d last %0b",
               $realtime, what, want.value, want.column, want.last,
               got.value, got.column, got.last);
    end
    failures++;
  endtask

  task automatic accumulate(logic [2:0] tag, logic signed [15:0] val);
    int ncols;
    if (elem_count == 0) begin
      row_expert = tag;
      for (int j = 0; j < OUT_COLS_DEF; j++) begin
        col_sum[j] = bias_enable ?
          longint'(bias_mem[row_expert * OUT_COLS_DEF + j]) * 256 : 0;
      end
    end
    if (row_expert < NUM_EXPERTS_DEF && elem_count < INNER_DIM_DEF) begin
      for (int j = 0; j < OUT_COLS_DEF; j++) begin
        col_sum[j] += longint'(weight_mem[(row_expert * INNER_DIM_DEF + elem_count)
                                          * OUT_COLS_DEF + j]) * longint'(val);
      end
    end
    elem_count++;
    if (elem_count >= clamp_len(inner_len, INNER_DIM_DEF)) begin
      elem_count = 0;
      ncols = clamp_len(out_cols, OUT_COLS_DEF);
      for (int j = 0; j < ncols; j++) begin
        pending_cols.push_back(col_result_t'{saturate32(col_sum[j]), j[3:0], j == ncols - 1});
      end
    end
  endtask

  task automatic absorb(logic [1:0] cmd, logic [31:0] d);
    logic [2:0]         tag;
    logic [5:0]         ipos;
    logic [3:0]         col;
    logic signed [15:0] val;
    tag  = d[2:0];
    ipos = d[8:3];
    col  = d[12:9];
    val  = d[28:13];
    case (cmd)
      CMD_WEIGHT: begin
        weight_mem[(int'(tag) * INNER_DIM_DEF + int'(ipos)) * OUT_COLS_DEF + int'(col)] = val;
      end
      CMD_BIAS: begin
        bias_mem[int'(tag) * OUT_COLS_DEF + int'(col)] = val;
      end
      CMD_ACT: begin
        accumulate(tag, val);
      end
      default: ;
    endcase
  endtask

  task automatic compare_beat();
    col_result_t got;
    col_result_t want;
    got.value  = m_tdata[31:0];
    got.column = m_tdata[35:32];
    got.last   = m_tlast;
    checked++;
    if (pending_cols.size() == 0) begin
      note_failure("output beat with nothing pending", '0, got);
    end else begin
      want = pending_cols.pop_front();
      if (got.value !== want.value || got.column !== want.column || got.last !== want.last)
        note_failure("output mismatch", want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pending_cols.delete();
      elem_count  = 0;
      row_expert  = 0;
      inner_len   = INNER_LEN_RST;
      out_cols    = OUT_COLS_RST;
      bias_enable = BIAS_ENABLE_RST;
      for (int j = 0; j < OUT_COLS_DEF; j++) col_sum[j] = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INNER_LEN:   inner_len   = cfg_data;
          REG_OUT_COLS:    out_cols    = cfg_data[4:0];
          REG_BIAS_ENABLE: bias_enable = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) absorb(s_tuser, s_tdata);
      if (m_tvalid && m_tready) compare_beat();
    end
    outstanding <= pending_cols.size();
  end

endmodule

FILE: bench/tb_segmented_expert_matmul_bias_top.sv
// Testbench top for segmented_expert_matmul_bias_top: drives loads, activation rows and
// register writes with random bursts and output stalls; semmb_result_checker judges.
// Depends on semmb_pkg, semmb_result_checker and the block itself.
module tb_segmented_expert_matmul_bias_top;
  import semmb_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 40;
  localparam int LONG_HOLD     = 400;
  localparam int ITEM_TARGET   = 500;
  localparam int WT_DEPTH      = NUM_EXPERTS_DEF * INNER_DIM_DEF * OUT_COLS_DEF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;

  int failures;
  int outstanding;
  int checked;

  bit         wt_ok [WT_DEPTH];
  bit         bias_ok [NUM_EXPERTS_DEF * OUT_COLS_DEF];
  logic [6:0] inner_len_set = INNER_LEN_RST;
  int         row_pos;
  int         row_owner;
  int         burst_left;
  bit         hold_req;
  int         beats, elements, rows_done, loads, noise_beats, cfg_writes;

  segmented_expert_matmul_bias_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  semmb_result_checker result_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .failures    (failures),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [15:0] rand_q88();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 1023)) - 512);
  endfunction

  function automatic int row_len(logic [6:0] v);
    if (v == 0) return 1;
    return (v > INNER_DIM_DEF) ? INNER_DIM_DEF : int'(v);
  endfunction

  task automatic send_beat(logic [1:0] cmd, logic [2:0] tag, logic [5:0] ipos,
                           logic [3:0] col, logic [15:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {3'b000, val, col, ipos, tag};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    beats++;
  endtask

  task automatic load_weight(int e, int k, int c, logic [15:0] v);
    wt_ok[(e * INNER_DIM_DEF + k) * OUT_COLS_DEF + c] = 1'b1;
    send_beat(CMD_WEIGHT, 3'(e), 6'(k), 4'(c), v);
    loads++;
  endtask

  task automatic load_bias(int e, int c, logic [15:0] v);
    bias_ok[e * OUT_COLS_DEF + c] = 1'b1;
    send_beat(CMD_BIAS, 3'(e), 6'($urandom), 4'(c), v);
    loads++;
  endtask

  task automatic random_load();
    if ($urandom_range(0, 3) == 0)
      load_bias($urandom_range(0, 7), $urandom_range(0, 15), rand_q88());
    else
      load_weight($urandom_range(0, 7), $urandom_range(0, 63), $urandom_range(0, 15),
                  rand_q88());
  endtask

  // Fill any store entry this element will read before sending it.
  task automatic send_element(logic [2:0] tag, logic [15:0] val);
    int owner;
    owner = (row_pos == 0) ? int'(tag) : row_owner;
    if (row_pos == 0) begin
      for (int c = 0; c < OUT_COLS_DEF; c++)
        if (!bias_ok[owner * OUT_COLS_DEF + c]) load_bias(owner, c, rand_q88());
    end
    for (int c = 0; c < OUT_COLS_DEF; c++)
      if (!wt_ok[(owner * INNER_DIM_DEF + row_pos) * OUT_COLS_DEF + c])
        load_weight(owner, row_pos, c, rand_q88());
    send_beat(CMD_ACT, tag, 6'($urandom), 4'($urandom), val);
    elements++;
    if (row_pos == 0) row_owner = tag;
    row_pos++;
    if (row_pos >= row_len(inner_len_set)) begin
      row_pos = 0;
      rows_done++;
    end
  endtask

  task automatic settle();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [6:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_INNER_LEN) inner_len_set = val;
    cfg_writes++;
  endtask

  // Output side: stretches of always-ready, random, mostly-stalled and mostly-ready, plus one long hold.
  initial begin
    int mode;
    int span;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 120);
      repeat (span) begin
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    int len;
    int n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Saturation both ways, then bias only.
    write_reg(REG_INNER_LEN, 7'd3);
    write_reg(REG_OUT_COLS, 7'd16);
    write_reg(REG_BIAS_ENABLE, 7'd1);
    for (int c = 0; c < OUT_COLS_DEF; c++) load_bias(0, c, 16'h7fff);
    for (int k = 0; k < 3; k++)
      for (int c = 0; c < OUT_COLS_DEF; c++) load_weight(0, k, c, 16'h8000);
    repeat (3) send_element(3'd0, 16'h8000);
    repeat (3) send_element(3'd0, 16'h7fff);
    repeat (3) send_element(3'd0, 16'h0000);
    send_beat(CMD_UNUSED, 3'h7, 6'h3f, 4'hf, 16'hffff);
    noise_beats++;

    // Zero lengths act as one, oversized column count acts as full width.
    write_reg(REG_INNER_LEN, 7'd0);
    write_reg(REG_OUT_COLS, 7'd0);
    write_reg(REG_BIAS_ENABLE, 7'd0);
    send_element(3'd7, 16'h0001);
    write_reg(REG_OUT_COLS, 7'd31);
    send_element(3'd7, 16'hffff);

    // Register changes in the middle of a row.
    write_reg(REG_INNER_LEN, 7'd8);
    write_reg(REG_OUT_COLS, 7'd5);
    write_reg(REG_BIAS_ENABLE, 7'd1);
    repeat (4) send_element(3'd3, rand_q88());
    write_reg(REG_OUT_COLS, 7'd2);
    write_reg(REG_BIAS_ENABLE, 7'd0);
    write_reg(REG_INNER_LEN, 7'd2);
    send_element(3'd3, rand_q88());

    // Weight reload between elements of one row.
    write_reg(REG_INNER_LEN, 7'd3);
    send_element(3'd2, rand_q88());
    for (int c = 0; c < OUT_COLS_DEF; c++) load_weight(2, 1, c, rand_q88());
    repeat (2) send_element(3'd2, rand_q88());

    // Back up the output while the input keeps offering single-element rows.
    write_reg(REG_INNER_LEN, 7'd1);
    write_reg(REG_OUT_COLS, 7'd16);
    write_reg(REG_BIAS_ENABLE, 7'd1);
    hold_req = 1'b1;
    repeat (48) send_element(($urandom_range(0, 1) == 0) ? 3'd0 : 3'd7, rand_q88());

    while (beats < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       write_reg(REG_INNER_LEN, 7'd0);
        1:       write_reg(REG_INNER_LEN, 7'd1);
        default: write_reg(REG_INNER_LEN, 7'($urandom_range(2, 8)));
      endcase
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 5))
          0:       write_reg(REG_OUT_COLS, 7'd0);
          1:       write_reg(REG_OUT_COLS, 7'd16);
          2:       write_reg(REG_OUT_COLS, 7'($urandom_range(17, 31)));
          default: write_reg(REG_OUT_COLS, 7'($urandom_range(1, 15)));
        endcase
      end
      if ($urandom_range(0, 1) == 0) write_reg(REG_BIAS_ENABLE, 7'($urandom_range(0, 1)));
      len = row_len(inner_len_set);
      n = len * ((len > 16) ? $urandom_range(1, 2) : $urandom_range(1, 6));
      if (len > 1 && $urandom_range(0, 3) == 0) n += $urandom_range(1, len - 1);
      for (int i = 0; i < n; i++) begin
        if (beats >= ITEM_TARGET) break;
        if ($urandom_range(0, 7) == 0) random_load();
        if ($urandom_range(0, 24) == 0) begin
          send_beat(CMD_UNUSED, 3'($urandom), 6'($urandom), 4'($urandom), 16'($urandom));
          noise_beats++;
        end
        send_element(3'($urandom), rand_q88());
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d beats: %0d activation elements in %0d rows, %0d loads, %0d unused",
             beats, elements, rows_done, loads, noise_beats);
    $display("Compared %0d result beats over %0d register writes incl. zero and oversize values",
             checked, cfg_writes);
    if (failures == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
